### hdl/wrcp_pkg.sv
// Package for the WebP RIFF container parser: payload structs, phase codes,
// tag constants and the chunk kind function. Depends on nothing.
package wrcp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WEBP = 32'h5042_4557;
  localparam logic [31:0] TAG_VP8  = 32'h2038_5056;
  localparam logic [31:0] TAG_VP8L = 32'h4C38_5056;
  localparam logic [31:0] TAG_VP8X = 32'h5838_5056;
  localparam logic [31:0] TAG_ICCP = 32'h5043_4349;
  localparam logic [31:0] MAX_FILE_SIZE = 32'hFFFF_FFF6;
  localparam logic [32:0] OFFSET_MAX = 33'h1_FFFF_FFFF;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_SHORT_HDR = 4'd1, ST_BAD_MAGIC = 4'd2, ST_SIZE_MAX = 4'd3,
    ST_DATA_SHORT = 4'd4, ST_CHDR_SHORT = 4'd5, ST_CHUNK_SHORT = 4'd6,
    ST_PAD_MISSING = 4'd7, ST_PAD_NONZERO = 4'd8, ST_VP8X_SMALL = 4'd9,
    ST_BAD_FIRST = 4'd10
  } status_t;

  typedef enum logic [2:0] {
    PH_FHDR, PH_CHDR, PH_PAY, PH_PAD, PH_TAIL, PH_CHDR1, PH_PAY1, PH_PAD1
  } phase_t;

  typedef enum logic [2:0] {
    ROLE_FHDR = 3'd0, ROLE_CHDR = 3'd1, ROLE_PAY = 3'd2, ROLE_PAD = 3'd3,
    ROLE_IGN = 3'd4
  } role_t;

  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0, KIND_VP8 = 3'd1, KIND_VP8L = 3'd2, KIND_VP8X = 3'd3,
    KIND_ICCP = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  byte_value;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_length;
    logic [2:0]  chunk_kind;
    logic [1:0]  layout_kind;
    logic [7:0]  feature_flags;
    logic [24:0] canvas_width;
    logic [24:0] canvas_height;
    logic [3:0]  status_code;
    logic        status_final;
  } out_item_t;

  // Classified byte handed from the front part to the back part.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       is_fhdr;
    logic       is_active;
  } work_t;

  function automatic logic [2:0] kind_of(input logic [31:0] tag);
    if (tag == TAG_VP8) return KIND_VP8;
    if (tag == TAG_VP8L) return KIND_VP8L;
    if (tag == TAG_VP8X) return KIND_VP8X;
    if (tag == TAG_ICCP) return KIND_ICCP;
    return KIND_OTHER;
  endfunction

endpackage

### hdl/wrcp_front.sv
// Front part: accepts bytes, counts the header bytes and flags them.
// Depends on wrcp_pkg only; it takes no state back from the back part.
module wrcp_front import wrcp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     w_valid,
  input  logic     w_stall,
  output work_t    w_item
);

  logic [3:0] hcount;

  assign in_stall = w_stall;
  assign w_valid  = in_valid;
  assign w_item.data_byte = in_item.data_byte;
  assign w_item.last_byte = in_item.last_byte;
  assign w_item.is_fhdr   = (hcount != 4'd12);
  assign w_item.is_active = 1'b1;

  // Header byte counter, saturating at twelve and restarting per file.
  always_ff @(posedge clk) begin
    if (rst) begin
      hcount <= 4'd0;
    end else if (in_valid && !in_stall) begin
      if (in_item.last_byte) hcount <= 4'd0;
      else if (hcount != 4'd12) hcount <= hcount + 4'd1;
    end
  end

endmodule

### hdl/wrcp_queue.sv
// Short queue between the front and back parts.
// Depends on wrcp_pkg for the work item type.
module wrcp_queue import wrcp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_stall,
  input  work_t wr_item,
  output logic  rd_valid,
  input  logic  rd_stall,
  output work_t rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  work_t          slots [DEPTH];
  logic [AW-1:0]  wp, rp;
  logic [AW:0]    count;
  logic           push, pop;

  assign wr_stall = (count == (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rp];
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && !rd_stall;

  // Pointer and fill bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (push) wp <= (wp == AW'(DEPTH-1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(DEPTH-1)) ? '0 : rp + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= wr_item;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue overfilled");
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    (count == (AW+1)'(DEPTH)) |-> wr_stall) else $error("full queue not stalling");
  a_empty_hold: assert property (@(posedge clk) disable iff (rst)
    (count == '0 && !push) |=> !rd_valid) else $error("phantom entry");
`endif

endmodule

### hdl/wrcp_back.sv
// Back part: chunk walk, VP8X decode, error latching and the output register.
// Depends on wrcp_pkg.
module wrcp_back import wrcp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      w_valid,
  output logic      w_stall,
  input  work_t     w_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [32:0] byte_offset, file_end, chunk_remaining;
  phase_t      parse_phase;
  logic [63:0] header_shift;
  logic [31:0] current_tag, current_length;
  logic [1:0]  layout_reg;
  logic [7:0]  flags_reg;
  logic [24:0] width_reg, height_reg;
  logic [3:0]  latched_error;

  logic [32:0] byte_offset_next, file_end_next, chunk_remaining_next;
  phase_t      parse_phase_next;
  logic [63:0] header_shift_next;
  logic [31:0] current_tag_next, current_length_next;
  logic [1:0]  layout_reg_next;
  logic [7:0]  flags_reg_next;
  logic [24:0] width_reg_next, height_reg_next;
  logic [3:0]  latched_error_next;
  out_item_t   res;
  logic        take;

  // The output register frees whenever it is empty or being taken.
  assign w_stall = out_valid && out_stall;
  assign take = w_valid && !w_stall;

  always_comb begin
    logic [7:0]  b;
    logic [32:0] off, pos, avail, rem;
    logic [63:0] hs;
    logic        first, fin, last;
    logic [2:0]  role;
    logic [2:0]  k;
    logic [32:0] idx;
    logic [3:0]  status;
    b = w_item.data_byte;
    last = w_item.last_byte;
    off = byte_offset;
    pos = (off < OFFSET_MAX) ? off + 33'd1 : OFFSET_MAX;
    first = (parse_phase == PH_CHDR1) || (parse_phase == PH_PAY1) ||
            (parse_phase == PH_PAD1);
    role = ROLE_IGN;
    fin = 1'b0;
    hs = {b, header_shift[63:8]};
    avail = (file_end > pos) ? file_end - pos : 33'd0;
    k = KIND_OTHER;
    idx = {1'b0, current_length} - chunk_remaining;
    byte_offset_next = pos;
    file_end_next = file_end;
    chunk_remaining_next = chunk_remaining;
    parse_phase_next = parse_phase;
    header_shift_next = header_shift;
    current_tag_next = current_tag;
    current_length_next = current_length;
    layout_reg_next = layout_reg;
    flags_reg_next = flags_reg;
    width_reg_next = width_reg;
    height_reg_next = height_reg;
    latched_error_next = latched_error;
    rem = 33'd0;

    if (w_item.is_fhdr) begin
      // File header: shift in, check magic and size on fixed offsets.
      role = ROLE_FHDR;
      header_shift_next = hs;
      if (off == 33'd3 && hs[63:32] != TAG_RIFF && latched_error_next == ST_OK)
        latched_error_next = ST_BAD_MAGIC;
      if (off == 33'd11) begin
        if (latched_error_next != ST_OK) begin
          parse_phase_next = PH_TAIL;
        end else if (hs[63:32] != TAG_WEBP) begin
          latched_error_next = ST_BAD_MAGIC;
          parse_phase_next = PH_TAIL;
        end else if (hs[31:0] > MAX_FILE_SIZE) begin
          latched_error_next = ST_SIZE_MAX;
          parse_phase_next = PH_TAIL;
        end else begin
          file_end_next = {1'b0, hs[31:0]} + 33'd8;
          rem = (file_end_next > pos) ? file_end_next - pos : 33'd0;
          if (rem < 33'd8) begin
            latched_error_next = ST_CHDR_SHORT;
            parse_phase_next = PH_TAIL;
          end else begin
            chunk_remaining_next = 33'd8;
            parse_phase_next = PH_CHDR1;
          end
        end
      end
    end else if (off >= file_end || parse_phase == PH_TAIL) begin
      role = ROLE_IGN;
    end else if (parse_phase == PH_CHDR || parse_phase == PH_CHDR1) begin
      // Chunk header: on its last byte check fit and padding room.
      role = ROLE_CHDR;
      header_shift_next = hs;
      chunk_remaining_next = chunk_remaining - 33'd1;
      if (chunk_remaining_next == 33'd0) begin
        current_tag_next = hs[31:0];
        current_length_next = hs[63:32];
        if ({1'b0, hs[63:32]} > avail) begin
          if (latched_error_next == ST_OK) latched_error_next = ST_CHUNK_SHORT;
          parse_phase_next = PH_TAIL;
        end else if (hs[32] && ({1'b0, hs[63:32]} + 33'd1 > avail)) begin
          if (latched_error_next == ST_OK) latched_error_next = ST_PAD_MISSING;
          parse_phase_next = PH_TAIL;
        end else begin
          if (first) begin
            k = kind_of(hs[31:0]);
            layout_reg_next = (k >= KIND_VP8 && k <= KIND_VP8X) ? k[1:0] : 2'd0;
          end
          chunk_remaining_next = {1'b0, hs[63:32]};
          if (hs[63:32] == 32'd0) fin = 1'b1;
          else parse_phase_next = first ? PH_PAY1 : PH_PAY;
        end
      end
    end else if (parse_phase == PH_PAY || parse_phase == PH_PAY1) begin
      // Payload: decode the leading VP8X fields.
      role = ROLE_PAY;
      if (first && current_tag == TAG_VP8X && current_length >= 32'd10) begin
        if (idx == 33'd0) flags_reg_next = b;
        if (idx >= 33'd4 && idx <= 33'd9) header_shift_next = hs;
        if (idx == 33'd6) width_reg_next = {1'b0, hs[63:40]} + 25'd1;
        if (idx == 33'd9) height_reg_next = {1'b0, hs[63:40]} + 25'd1;
      end
      chunk_remaining_next = chunk_remaining - 33'd1;
      if (chunk_remaining_next == 33'd0) fin = 1'b1;
    end else if (parse_phase == PH_PAD || parse_phase == PH_PAD1) begin
      role = ROLE_PAD;
      if (b != 8'd0) begin
        if (latched_error_next == ST_OK) latched_error_next = ST_PAD_NONZERO;
        parse_phase_next = PH_TAIL;
      end else begin
        fin = 1'b1;
        if (parse_phase == PH_PAD) fin = 1'b1;
      end
    end else begin
      parse_phase_next = PH_TAIL;
    end

    // End of payload: padding first, else finish the chunk.
    if (fin) begin
      logic go_next;
      go_next = 1'b0;
      if (role != ROLE_PAD && current_length_next[0]) begin
        parse_phase_next = first ? PH_PAD1 : PH_PAD;
      end else if (!first) begin
        go_next = 1'b1;
      end else begin
        case (kind_of(current_tag_next))
          KIND_VP8, KIND_VP8L: parse_phase_next = PH_TAIL;
          KIND_VP8X: begin
            if (current_length_next < 32'd10) begin
              if (latched_error_next == ST_OK) latched_error_next = ST_VP8X_SMALL;
              parse_phase_next = PH_TAIL;
            end else begin
              go_next = 1'b1;
            end
          end
          default: begin
            if (latched_error_next == ST_OK) latched_error_next = ST_BAD_FIRST;
            parse_phase_next = PH_TAIL;
          end
        endcase
      end
      if (go_next) begin
        if (avail == 33'd0) begin
          parse_phase_next = PH_TAIL;
        end else if (avail < 33'd8) begin
          if (latched_error_next == ST_OK) latched_error_next = ST_CHDR_SHORT;
          parse_phase_next = PH_TAIL;
        end else begin
          chunk_remaining_next = 33'd8;
          parse_phase_next = PH_CHDR;
        end
      end
    end

    // Status resolution on the last byte.
    status = latched_error_next;
    if (last) begin
      if (parse_phase_next == PH_FHDR) status = ST_SHORT_HDR;
      else if (latched_error_next == ST_BAD_MAGIC || latched_error_next == ST_SIZE_MAX)
        status = latched_error_next;
      else if (pos < file_end_next) status = ST_DATA_SHORT;
    end

    res.byte_role = role;
    res.byte_value = b;
    res.chunk_tag = current_tag_next;
    res.chunk_length = current_length_next;
    res.chunk_kind = kind_of(current_tag_next);
    res.layout_kind = layout_reg_next;
    res.feature_flags = flags_reg_next;
    res.canvas_width = width_reg_next;
    res.canvas_height = height_reg_next;
    res.status_code = status;
    res.status_final = last;
  end

  // Parser state, cleared after the last byte of each file.
  always_ff @(posedge clk) begin
    if (rst || (take && w_item.last_byte)) begin
      byte_offset <= '0; file_end <= '0; chunk_remaining <= '0;
      parse_phase <= PH_FHDR; header_shift <= '0; current_tag <= '0;
      current_length <= '0; layout_reg <= '0; flags_reg <= '0;
      width_reg <= '0; height_reg <= '0; latched_error <= '0;
    end else if (take) begin
      byte_offset <= byte_offset_next; file_end <= file_end_next;
      chunk_remaining <= chunk_remaining_next; parse_phase <= parse_phase_next;
      header_shift <= header_shift_next; current_tag <= current_tag_next;
      current_length <= current_length_next; layout_reg <= layout_reg_next;
      flags_reg <= flags_reg_next; width_reg <= width_reg_next;
      height_reg <= height_reg_next; latched_error <= latched_error_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (take) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) out_item <= res;
  end

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (take && !w_item.last_byte && latched_error != ST_OK) |=>
      latched_error == $past(latched_error)) else $error("error not latched");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
    else $error("result lost under stall");
  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    (take && w_item.last_byte) |=> (byte_offset == '0 && parse_phase == PH_FHDR))
    else $error("no restart after last byte");
`endif

endmodule

### hdl/webp_riff_container_parser.sv
// WebP RIFF container parser, one result per byte.
// Path: each accepted byte passes through the queue, then the output register.
// Throughput: one byte per cycle while out_stall is low, as the back part walks chunks combinationally.
// Reset: synchronous, active high; the parser also returns to reset after each last byte.
// Depends on wrcp_pkg, wrcp_front, wrcp_queue and wrcp_back.
module webp_riff_container_parser import wrcp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic  f_valid, f_stall, q_valid, q_stall;
  work_t f_item, q_item;

  wrcp_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item,
    .w_valid(f_valid), .w_stall(f_stall), .w_item(f_item)
  );

  wrcp_queue #(.DEPTH(DEPTH)) u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_item(f_item),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_item(q_item)
  );

  wrcp_back u_back (
    .clk, .rst, .w_valid(q_valid), .w_stall(q_stall), .w_item(q_item),
    .out_valid, .out_stall, .out_item
  );

endmodule
